/* rtl/bts_pkg.sv */
`default_nettype none

package bts_pkg;

    // Command codes of an input beat
    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;

    typedef enum logic [CFG_INDEX_BITS-1:0]
    {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    // Texel layout: red 7:0, green 15:8, blue 23:16
    localparam int CHAN_BITS   = 8;
    localparam int NUM_CHAN    = 3;
    localparam int TEXEL_BITS  = CHAN_BITS * NUM_CHAN;
    localparam int COORD_BITS  = 16;
    localparam int INDEX_BITS  = 16;
    localparam int SAMPLE_BITS = 16;

endpackage

`default_nettype wire

/* rtl/bts_ram.sv */
`default_nettype none

module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

/* rtl/bilinear_texture_sampler.sv */
`default_nettype none

// Bilinear texture sampler. Load beats (command 0) write one RGB texel at
// texel_index; sample beats (command 1) return one filtered 8.8 color per
// channel, clamped to the right and top edges. The block takes one beat per
// clock, loads and samples mixed freely; a sample passes through stages 1 to 5
// and then into the output register. The rate is set by the texel store: it
// is kept as two identical copies, each with two read ports, so the four
// neighbours of a sample are fetched together, and every load writes both
// copies at the same pipeline stage where samples read, so loads and samples
// see the store in beat order. in_ready drops only while a finished sample
// sits in the last stage and the output register is full and not taken. The
// store has no reset; sampling a texel that was never loaded gives undefined
// color. Configuration writes are accepted every cycle and must only be made
// while the block is idle.
module bilinear_texture_sampler #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              command,
    input  wire logic [bts_pkg::INDEX_BITS-1:0]    texel_index,
    input  wire logic [bts_pkg::CHAN_BITS-1:0]     load_red,
    input  wire logic [bts_pkg::CHAN_BITS-1:0]     load_green,
    input  wire logic [bts_pkg::CHAN_BITS-1:0]     load_blue,
    input  wire logic [bts_pkg::COORD_BITS-1:0]    coord_u,
    input  wire logic [bts_pkg::COORD_BITS-1:0]    coord_v,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [bts_pkg::SAMPLE_BITS-1:0]   sample_red,
    output logic      [bts_pkg::SAMPLE_BITS-1:0]   sample_green,
    output logic      [bts_pkg::SAMPLE_BITS-1:0]   sample_blue,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CB    = bts_pkg::CHAN_BITS;
    localparam int NCH   = bts_pkg::NUM_CHAN;
    localparam int TB    = bts_pkg::TEXEL_BITS;
    localparam int UB    = bts_pkg::COORD_BITS;
    localparam int WB    = WEIGHT_BITS;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = CB + WB;
    localparam int ACW   = CB + 2 * WB + 1;
    localparam int SH    = 2 * WB - 8;
    localparam logic [WB:0]    WONE = (WB + 1)'(1) << WB;
    localparam logic [ACW-1:0] RND  =
        (SH > 0) ? (ACW'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;

    // Configuration registers
    logic [bts_pkg::CFG_DATA_BITS-1:0] width_reg;
    logic [bts_pkg::CFG_DATA_BITS-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bts_pkg::CFG_DATA_BITS'(256);
            height_reg <= bts_pkg::CFG_DATA_BITS'(256);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bts_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bts_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective size: zero reads as one, large values saturate
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    // Pipeline advance: stall only when a result cannot leave
    logic advance;
    logic smp_s1_reg, smp_s2_reg, smp_s3_reg, smp_s4_reg, smp_s5_reg;
    logic ld_s1_reg, ld_s2_reg;
    logic out_valid_reg;

    assign advance  = !smp_s5_reg || !out_valid_reg || out_ready;
    assign in_ready = advance;

    logic in_beat;
    assign in_beat = in_valid && advance;

    // Stage 0: scale coordinates by texture size
    logic [UB+WW-1:0] su;
    logic [UB+HW-1:0] sv;

    assign su = (UB + WW)'(coord_u) * (UB + WW)'(w_eff);
    assign sv = (UB + HW)'(coord_v) * (UB + HW)'(h_eff);

    logic [CW-1:0] col_s1_reg;
    logic [RW-1:0] row_s1_reg;
    logic [WB-1:0] ds_s1_reg, dt_s1_reg;
    logic [AW-1:0] ld_addr_s1_reg, ld_addr_s2_reg;
    logic [TB-1:0] ld_data_s1_reg, ld_data_s2_reg;

    // Stage 1: neighbour columns and rows, row offsets
    logic [CW-1:0] col1;
    logic [RW-1:0] row1;

    always_comb
    begin
        if ((WW'(col_s1_reg) + WW'(1)) < w_eff)
            col1 = col_s1_reg + CW'(1);
        else
            col1 = CW'(w_eff - WW'(1));

        if ((HW'(row_s1_reg) + HW'(1)) < h_eff)
            row1 = row_s1_reg + RW'(1);
        else
            row1 = RW'(h_eff - HW'(1));
    end

    logic [AW-1:0] rw0_s2_reg, rw1_s2_reg;
    logic [CW-1:0] col0_s2_reg, col1_s2_reg;
    logic [WB-1:0] ds_s2_reg, dt_s2_reg;

    // Stage 2: store addresses, memory read and load write
    logic [AW-1:0] a00, a01, a10, a11;

    assign a00 = rw0_s2_reg + AW'(col0_s2_reg);
    assign a01 = rw0_s2_reg + AW'(col1_s2_reg);
    assign a10 = rw1_s2_reg + AW'(col0_s2_reg);
    assign a11 = rw1_s2_reg + AW'(col1_s2_reg);

    logic ram_we;
    assign ram_we = advance && ld_s2_reg;

    logic [TB-1:0] t00, t01, t10, t11;

    bts_ram #(
        .WIDTH (TB),
        .DEPTH (DEPTH)
    ) u_store_lo (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ld_addr_s2_reg),
        .wdata   (ld_data_s2_reg),
        .re      (advance),
        .raddr_a (a00),
        .raddr_b (a01),
        .rdata_a (t00),
        .rdata_b (t01)
    );

    bts_ram #(
        .WIDTH (TB),
        .DEPTH (DEPTH)
    ) u_store_hi (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ld_addr_s2_reg),
        .wdata   (ld_data_s2_reg),
        .re      (advance),
        .raddr_a (a10),
        .raddr_b (a11),
        .rdata_a (t10),
        .rdata_b (t11)
    );

    logic [WB-1:0] ds_s3_reg, dt_s3_reg;

    // Stage 3: horizontal blend per channel
    logic [LW-1:0] lower_next [NCH];
    logic [LW-1:0] upper_next [NCH];

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            lower_next[ch] = LW'(t00[ch*CB +: CB]) * LW'(WONE - (WB + 1)'(ds_s3_reg))
                           + LW'(t01[ch*CB +: CB]) * LW'(ds_s3_reg);
            upper_next[ch] = LW'(t10[ch*CB +: CB]) * LW'(WONE - (WB + 1)'(ds_s3_reg))
                           + LW'(t11[ch*CB +: CB]) * LW'(ds_s3_reg);
        end
    end

    logic [LW-1:0] lower_s4_reg [NCH];
    logic [LW-1:0] upper_s4_reg [NCH];
    logic [WB-1:0] dt_s4_reg;

    // Stage 4: vertical blend per channel
    logic [ACW-1:0] acc_next [NCH];

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            acc_next[ch] = ACW'(lower_s4_reg[ch]) * ACW'(WONE - (WB + 1)'(dt_s4_reg))
                         + ACW'(upper_s4_reg[ch]) * ACW'(dt_s4_reg);
        end
    end

    logic [ACW-1:0] acc_s5_reg [NCH];

    // Stage 5: round half up to 8.8
    logic [ACW-1:0] rounded [NCH];

    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            rounded[ch] = (acc_s5_reg[ch] + RND) >> SH;
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_s1_reg <= 1'b0;
            smp_s2_reg <= 1'b0;
            smp_s3_reg <= 1'b0;
            smp_s4_reg <= 1'b0;
            smp_s5_reg <= 1'b0;
            ld_s1_reg  <= 1'b0;
            ld_s2_reg  <= 1'b0;
        end
        else if (advance)
        begin
            smp_s1_reg <= in_beat && (command == bts_pkg::CMD_SAMPLE);
            ld_s1_reg  <= in_beat && (command == bts_pkg::CMD_LOAD)
                          && (32'(texel_index) < DEPTH);
            smp_s2_reg <= smp_s1_reg;
            ld_s2_reg  <= ld_s1_reg;
            smp_s3_reg <= smp_s2_reg;
            smp_s4_reg <= smp_s3_reg;
            smp_s5_reg <= smp_s4_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            col_s1_reg     <= su[UB +: CW];
            row_s1_reg     <= sv[UB +: RW];
            ds_s1_reg      <= su[UB-1 -: WB];
            dt_s1_reg      <= sv[UB-1 -: WB];
            ld_addr_s1_reg <= AW'(texel_index);
            ld_data_s1_reg <= {load_blue, load_green, load_red};

            rw0_s2_reg     <= AW'(row_s1_reg) * AW'(w_eff);
            rw1_s2_reg     <= AW'(row1) * AW'(w_eff);
            col0_s2_reg    <= col_s1_reg;
            col1_s2_reg    <= col1;
            ds_s2_reg      <= ds_s1_reg;
            dt_s2_reg      <= dt_s1_reg;
            ld_addr_s2_reg <= ld_addr_s1_reg;
            ld_data_s2_reg <= ld_data_s1_reg;

            ds_s3_reg      <= ds_s2_reg;
            dt_s3_reg      <= dt_s2_reg;

            dt_s4_reg      <= dt_s3_reg;
            for (int ch = 0; ch < NCH; ch++)
            begin
                lower_s4_reg[ch] <= lower_next[ch];
                upper_s4_reg[ch] <= upper_next[ch];
                acc_s5_reg[ch]   <= acc_next[ch];
            end
        end
    end

    // Output register
    logic [bts_pkg::SAMPLE_BITS-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && smp_s5_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && smp_s5_reg)
        begin
            red_reg   <= rounded[0][bts_pkg::SAMPLE_BITS-1:0];
            green_reg <= rounded[1][bts_pkg::SAMPLE_BITS-1:0];
            blue_reg  <= rounded[2][bts_pkg::SAMPLE_BITS-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_red   = red_reg;
    assign sample_green = green_reg;
    assign sample_blue  = blue_reg;

    // Input stalls only behind a full, untaken output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready && smp_s5_reg))
        else $error("input stalled without a blocked result");

    // The far corner stays inside the texture
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        smp_s2_reg |-> (32'(a11) < (32'(h_eff) * 32'(w_eff))))
        else $error("neighbour address outside the texture");

    // Right neighbour is the same or the next column
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        smp_s2_reg |-> ((col1_s2_reg == col0_s2_reg)
                        || (WW'(col1_s2_reg) == WW'(col0_s2_reg) + WW'(1))))
        else $error("right neighbour column out of step");

endmodule

`default_nettype wire

/* bench/tb_bilinear_texture_sampler.sv */
`timescale 1ns / 1ps

module tb_bilinear_texture_sampler;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int WEIGHT_BITS  = 8;
    localparam int STORE_DEPTH  = 65536;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 10;

    // register indexes the block has no register behind
    localparam logic [bts_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [bts_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        bts_pkg::cmd_t                  cmd;
        logic [bts_pkg::INDEX_BITS-1:0] index;
        logic [bts_pkg::CHAN_BITS-1:0]  red;
        logic [bts_pkg::CHAN_BITS-1:0]  green;
        logic [bts_pkg::CHAN_BITS-1:0]  blue;
        logic [bts_pkg::COORD_BITS-1:0] u;
        logic [bts_pkg::COORD_BITS-1:0] v;
    } texture_beat_t;

    typedef struct packed {
        logic [bts_pkg::SAMPLE_BITS-1:0] red;
        logic [bts_pkg::SAMPLE_BITS-1:0] green;
        logic [bts_pkg::SAMPLE_BITS-1:0] blue;
    } color_t;

    // four neighbour addresses: (row,col) (row,col+1) (row+1,col) (row+1,col+1)
    typedef struct {
        logic [bts_pkg::INDEX_BITS-1:0] addr [4];
        int                             ds;
        int                             dt;
    } footprint_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid = 1'b0;
    logic                               in_ready;
    texture_beat_t                      in_beat = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [bts_pkg::SAMPLE_BITS-1:0]    sample_red;
    logic [bts_pkg::SAMPLE_BITS-1:0]    sample_green;
    logic [bts_pkg::SAMPLE_BITS-1:0]    sample_blue;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [bts_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [bts_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // configuration as the block should hold it
    logic [bts_pkg::CFG_DATA_BITS-1:0] cfg_width = 9'd256;
    logic [bts_pkg::CFG_DATA_BITS-1:0] cfg_height = 9'd256;

    // texel contents as the block should hold them, after accepted loads
    logic [bts_pkg::TEXEL_BITS-1:0] texel_mem [STORE_DEPTH];
    // addresses already queued for loading, so samples never read unwritten texels
    bit loaded_map [STORE_DEPTH];

    texture_beat_t beat_q [$];
    color_t        pending_colors [$];

    int pushed_beats   = 0;
    int accepted_beats = 0;
    int load_count     = 0;
    int sample_count   = 0;
    int checked_count  = 0;
    int cfg_count      = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int in_idle_odds   = 0;
    int out_idle_odds  = 0;
    int in_gap         = 0;
    int out_gap        = 0;

    always #5 clk = ~clk;

    bilinear_texture_sampler #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (in_beat.cmd),
        .texel_index  (in_beat.index),
        .load_red     (in_beat.red),
        .load_green   (in_beat.green),
        .load_blue    (in_beat.blue),
        .coord_u      (in_beat.u),
        .coord_v      (in_beat.v),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_red   (sample_red),
        .sample_green (sample_green),
        .sample_blue  (sample_blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // zero reads as one, anything past the maximum saturates
    function automatic int eff_size(int raw, int limit);
        if (raw == 0)
            return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    // scale coordinates and find the clamped neighbours and weights
    function automatic footprint_t locate(logic [bts_pkg::COORD_BITS-1:0] u,
                                          logic [bts_pkg::COORD_BITS-1:0] v);
        footprint_t fp;
        int w, h, su, sv, col, row, col1, row1;
        w = eff_size(int'(cfg_width), MAX_WIDTH);
        h = eff_size(int'(cfg_height), MAX_HEIGHT);
        su = int'(u) * w;
        sv = int'(v) * h;
        col = su >> 16;
        row = sv >> 16;
        fp.ds = (su & 32'hFFFF) >> (16 - WEIGHT_BITS);
        fp.dt = (sv & 32'hFFFF) >> (16 - WEIGHT_BITS);
        col1 = (col + 1 < w) ? col + 1 : w - 1;
        row1 = (row + 1 < h) ? row + 1 : h - 1;
        if (col > w - 1)
            col = w - 1;
        if (row > h - 1)
            row = h - 1;
        fp.addr[0] = bts_pkg::INDEX_BITS'(row * w + col);
        fp.addr[1] = bts_pkg::INDEX_BITS'(row * w + col1);
        fp.addr[2] = bts_pkg::INDEX_BITS'(row1 * w + col);
        fp.addr[3] = bts_pkg::INDEX_BITS'(row1 * w + col1);
        return fp;
    endfunction

    // one channel of the bilinear blend, rounded half up to 8.8
    function automatic logic [bts_pkg::SAMPLE_BITS-1:0] bilerp(int c00, int c01, int c10,
                                                               int c11, int ds, int dt);
        longint one, lower, upper, acc;
        int sh;
        one = longint'(1) << WEIGHT_BITS;
        sh = 2 * WEIGHT_BITS - 8;
        lower = c00 * (one - ds) + c01 * ds;
        upper = c10 * (one - ds) + c11 * ds;
        acc = lower * (one - dt) + upper * dt;
        if (sh > 0)
            acc = (acc + (longint'(1) << (sh - 1))) >> sh;
        return acc[bts_pkg::SAMPLE_BITS-1:0];
    endfunction

    // update the texel shadow or queue the filtered color of one accepted beat
    function automatic void apply_beat(texture_beat_t b);
        footprint_t fp;
        logic [bts_pkg::TEXEL_BITS-1:0] t [4];
        logic [bts_pkg::SAMPLE_BITS-1:0] ch_out [bts_pkg::NUM_CHAN];
        color_t c;
        if (b.cmd == bts_pkg::CMD_LOAD) begin
            texel_mem[b.index] = {b.blue, b.green, b.red};
            load_count++;
        end
        else begin
            fp = locate(b.u, b.v);
            for (int i = 0; i < 4; i++)
                t[i] = texel_mem[fp.addr[i]];
            for (int ch = 0; ch < bts_pkg::NUM_CHAN; ch++)
                ch_out[ch] = bilerp(
                    int'(t[0][bts_pkg::CHAN_BITS*ch +: bts_pkg::CHAN_BITS]),
                    int'(t[1][bts_pkg::CHAN_BITS*ch +: bts_pkg::CHAN_BITS]),
                    int'(t[2][bts_pkg::CHAN_BITS*ch +: bts_pkg::CHAN_BITS]),
                    int'(t[3][bts_pkg::CHAN_BITS*ch +: bts_pkg::CHAN_BITS]),
                    fp.ds, fp.dt);
            c.red = ch_out[0];
            c.green = ch_out[1];
            c.blue = ch_out[2];
            pending_colors.push_back(c);
            sample_count++;
        end
    endfunction

    function automatic void flag_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function automatic logic [bts_pkg::COORD_BITS-1:0] rand_coord(int size);
        int k;
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            3: return 16'(65535 - $urandom_range(0, 255));
            4: begin
                // lands just on a texel boundary
                k = $urandom_range(0, size - 1);
                return 16'(((k << 16) + size - 1) / size);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_load(logic [bts_pkg::INDEX_BITS-1:0] idx,
                                     logic [bts_pkg::CHAN_BITS-1:0] r,
                                     logic [bts_pkg::CHAN_BITS-1:0] g,
                                     logic [bts_pkg::CHAN_BITS-1:0] b);
        texture_beat_t beat;
        beat.cmd = bts_pkg::CMD_LOAD;
        beat.index = idx;
        beat.red = r;
        beat.green = g;
        beat.blue = b;
        beat.u = 16'($urandom);
        beat.v = 16'($urandom);
        beat_q.push_back(beat);
        loaded_map[idx] = 1'b1;
        pushed_beats++;
    endfunction

    // a sample preceded by loads of whichever neighbours are still unwritten
    function automatic void add_sample(logic [bts_pkg::COORD_BITS-1:0] u,
                                       logic [bts_pkg::COORD_BITS-1:0] v);
        footprint_t fp;
        texture_beat_t beat;
        fp = locate(u, v);
        for (int i = 0; i < 4; i++)
            if (!loaded_map[fp.addr[i]])
                add_load(fp.addr[i], 8'($urandom), 8'($urandom), 8'($urandom));
        beat.cmd = bts_pkg::CMD_SAMPLE;
        beat.index = 16'($urandom);
        beat.red = 8'($urandom);
        beat.green = 8'($urandom);
        beat.blue = 8'($urandom);
        beat.u = u;
        beat.v = v;
        beat_q.push_back(beat);
        pushed_beats++;
    endfunction

    // mostly samples with random content, the rest loads in and out of the image
    function automatic void fill_random(int beats);
        int target, w, h, pick;
        target = pushed_beats + beats;
        w = eff_size(int'(cfg_width), MAX_WIDTH);
        h = eff_size(int'(cfg_height), MAX_HEIGHT);
        while (pushed_beats < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                add_sample(rand_coord(w), rand_coord(h));
            else if (pick < 8)
                add_load(16'($urandom_range(0, w * h - 1)),
                         8'($urandom), 8'($urandom), 8'($urandom));
            else
                add_load(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endfunction

    task automatic wait_drained();
        while (accepted_beats != pushed_beats || pending_colors.size() != 0)
            @(posedge clk);
    endtask

    // drained, then loads still in the pipeline are given time to land
    task automatic settle();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [bts_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [bts_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == bts_pkg::CFG_IMAGE_WIDTH)
            cfg_width = data;
        else if (idx == bts_pkg::CFG_IMAGE_HEIGHT)
            cfg_height = data;
        cfg_count++;
    endtask

    // input driver: one beat per handshake, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else begin
            if (in_valid && in_ready) begin
                apply_beat(in_beat);
                accepted_beats++;
            end
            if (!in_valid || in_ready) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() > 0) begin
                    in_beat <= beat_q.pop_front();
                    in_valid <= 1'b1;
                    if (in_idle_odds != 0 && $urandom_range(1, in_idle_odds) == 1)
                        in_gap <= $urandom_range(1, 8);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        color_t got, want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                got.red = sample_red;
                got.green = sample_green;
                got.blue = sample_blue;
                if (pending_colors.size() == 0) begin
                    flag_failure($sformatf("unexpected result r=%h g=%h b=%h",
                                           got.red, got.green, got.blue));
                end
                else begin
                    want = pending_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                        flag_failure($sformatf(
                            "result %0d: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                            checked_count, want.red, want.green, want.blue,
                            got.red, got.green, got.blue));
                    checked_count++;
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
                if (out_idle_odds != 0 && $urandom_range(1, out_idle_odds) == 1)
                    out_gap <= $urandom_range(1, 8);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_bilinear_texture_sampler: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        int beats_per_phase;
        phase_w = '{1, 0, 256, 1, 2, 511, 3, 0, 100, 256};
        phase_h = '{1, 0, 1, 256, 2, 511, 7, 300, 37, 256};
        beats_per_phase = 162;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_odds = 4;
        out_idle_odds = 4;

        // directed: extreme colors, corners, zero and full weights, both edges
        add_load(16'd0, 8'hFF, 8'hFF, 8'hFF);
        add_load(16'd1, 8'h00, 8'h00, 8'h00);
        add_load(16'd256, 8'h00, 8'hFF, 8'h00);
        add_load(16'd257, 8'hFF, 8'h00, 8'hFF);
        add_sample(16'h0000, 16'h0000);
        add_sample(16'h0080, 16'h0080);
        add_sample(16'h00FF, 16'h00FF);
        add_load(16'd255, 8'hFF, 8'hFF, 8'hFF);
        add_load(16'd65280, 8'hFF, 8'hFF, 8'hFF);
        add_load(16'd65535, 8'hFF, 8'hFF, 8'hFF);
        add_sample(16'hFFFF, 16'hFFFF);
        add_sample(16'hFFFF, 16'h0000);
        add_sample(16'h0000, 16'hFFFF);
        add_load(16'h5555, 8'hA5, 8'h5A, 8'hC3);
        add_sample(16'h5555, 16'h5500);
        add_sample(16'h8000, 16'h8000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p == 7)
                phase_w[p] = $urandom_range(2, 40);
            write_reg(bts_pkg::CFG_IMAGE_WIDTH, bts_pkg::CFG_DATA_BITS'(phase_w[p]));
            write_reg(bts_pkg::CFG_IMAGE_HEIGHT, bts_pkg::CFG_DATA_BITS'(phase_h[p]));
            // writes to unused indexes must leave the size alone
            if (p == 6) begin
                write_reg(CFG_SPARE_2, 9'h1FF);
                write_reg(CFG_SPARE_3, 9'h000);
            end
            if (p == NUM_PHASES - 1) begin
                in_idle_odds = 0;
                out_idle_odds = 0;
            end
            else begin
                in_idle_odds = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
                out_idle_odds = ((p + 1) % 3 == 0) ? 0 : (((p + 1) % 3 == 1) ? 3 : 10);
            end
            // hold the sender halfway until every result is back
            fill_random(beats_per_phase / 2);
            wait_drained();
            fill_random(beats_per_phase - beats_per_phase / 2);
        end

        settle();
        if (pending_colors.size() != 0) begin
            $display("%0d expected results never arrived", pending_colors.size());
            fail_count += pending_colors.size();
        end
        $display("covered %0d loads and %0d samples over %0d size settings, %0d writes",
                 load_count, sample_count, NUM_PHASES + 1, cfg_count);
        $display("checked %0d filtered colors, %0d failures", checked_count, fail_count);
        if (fail_count == 0)
            $display("tb_bilinear_texture_sampler: PASS");
        else
            $display("tb_bilinear_texture_sampler: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/bts_pkg.sv
rtl/bts_ram.sv
rtl/bilinear_texture_sampler.sv
bench/tb_bilinear_texture_sampler.sv
